FILE: rtl/planar_odometry_integrator_macros.svh
// Assertion helpers shared by the odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/poi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

    localparam int SINE_TABLE_ENTRIES_DEF = 1024;

    localparam int VEL_W  = 16;
    localparam int YAW_W  = 21;
    localparam int DT_W   = 16;
    localparam int POS_W  = 32;
    localparam int HEAD_W = 17;
    localparam int Q_W    = 16;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = 50;

    localparam logic [15:0]       PHASE_QUARTER = 16'h4000;
    localparam logic [HEAD_W-1:0] HEAD_HALF     = 17'h08000;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // Taylor series term divisors: (2i)(2i+1) for sine, (2i-1)(2i) for cosine.
    localparam longint unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        ROM_NONE,
        ROM_SIN,
        ROM_COS,
        ROM_QZ,
        ROM_QW
    } rom_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_S,
        CAP_C,
        CAP_QZ,
        CAP_QW
    } cap_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WZ_DT,
        MUL_VF_S,
        MUL_VS_C,
        MUL_VF_C,
        MUL_VS_S,
        MUL_ACC_DT
    } mul_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_t;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_HEADING,
        WB_Y,
        WB_X
    } wb_t;

    typedef enum logic [0:0] {
        SEQ_NEXT,
        SEQ_END
    } seq_t;

    typedef struct packed {
        rom_sel_t rom;
        cap_t     cap;
        mul_t     mul;
        acc_t     acc;
        wb_t      wb;
        seq_t     seq;
    } uword_t;

    localparam int UC_DEPTH = 10;
    localparam int PC_W     = $clog2(UC_DEPTH);
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(UC_DEPTH - 1);

    // A ROM read issued in one step is captured in the next one.
    // The product of one step is consumed by the accumulator or a writeback in the next.
    localparam uword_t UCODE [UC_DEPTH] = '{
        '{ROM_SIN,  CAP_NONE, MUL_WZ_DT,  ACC_HOLD, WB_NONE,    SEQ_NEXT},
        '{ROM_COS,  CAP_S,    MUL_NONE,   ACC_HOLD, WB_HEADING, SEQ_NEXT},
        '{ROM_QZ,   CAP_C,    MUL_VF_S,   ACC_HOLD, WB_NONE,    SEQ_NEXT},
        '{ROM_QW,   CAP_QZ,   MUL_VS_C,   ACC_LOAD, WB_NONE,    SEQ_NEXT},
        '{ROM_NONE, CAP_QW,   MUL_VF_C,   ACC_ADD,  WB_NONE,    SEQ_NEXT},
        '{ROM_NONE, CAP_NONE, MUL_ACC_DT, ACC_LOAD, WB_NONE,    SEQ_NEXT},
        '{ROM_NONE, CAP_NONE, MUL_VS_S,   ACC_HOLD, WB_Y,       SEQ_NEXT},
        '{ROM_NONE, CAP_NONE, MUL_NONE,   ACC_SUB,  WB_NONE,    SEQ_NEXT},
        '{ROM_NONE, CAP_NONE, MUL_ACC_DT, ACC_HOLD, WB_NONE,    SEQ_NEXT},
        '{ROM_NONE, CAP_NONE, MUL_NONE,   ACC_HOLD, WB_X,       SEQ_END}
    };

endpackage

`default_nettype wire

FILE: rtl/poi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface poi_in_if;

    logic                               valid;
    logic                               ready;
    logic signed [poi_pkg::VEL_W-1:0]   vel_forward;
    logic signed [poi_pkg::VEL_W-1:0]   vel_side;
    logic signed [poi_pkg::YAW_W-1:0]   yaw_rate;
    logic        [poi_pkg::DT_W-1:0]    elapsed_time;

    modport source (
        output valid,
        output vel_forward,
        output vel_side,
        output yaw_rate,
        output elapsed_time,
        input  ready
    );

    modport sink (
        input  valid,
        input  vel_forward,
        input  vel_side,
        input  yaw_rate,
        input  elapsed_time,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/poi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface poi_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [poi_pkg::POS_W-1:0]   pos_x;
    logic signed [poi_pkg::POS_W-1:0]   pos_y;
    logic        [poi_pkg::HEAD_W-1:0]  heading;
    logic signed [poi_pkg::Q_W-1:0]     quat_z;
    logic signed [poi_pkg::Q_W-1:0]     quat_w;

    modport source (
        output valid,
        output pos_x,
        output pos_y,
        output heading,
        output quat_z,
        output quat_w,
        input  ready
    );

    modport sink (
        input  valid,
        input  pos_x,
        input  pos_y,
        input  heading,
        input  quat_z,
        input  quat_w,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/planar_odometry_integrator.sv
// Requests are accepted only while idle, so a new one waits until the program ends.
// Ten microcode steps run in order and share one 33x17 multiplier and the single
// read port of the sine ROM. The result is registered at the end of the last step.
// The last step waits while the previous result has not been taken.
// Reset clears position and heading to zero and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_odometry_integrator_macros.svh"

module planar_odometry_integrator #(
    parameter int SINE_TABLE_ENTRIES = poi_pkg::SINE_TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    poi_in_if.sink      cmd,
    poi_out_if.source   odom
);

    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
    localparam int PH_W  = poi_pkg::HEAD_W + IDX_W + 1;
    localparam longint unsigned ROM_N = SINE_TABLE_ENTRIES;

    localparam logic [PH_W-1:0] PH_ENTRIES = PH_W'(SINE_TABLE_ENTRIES);
    localparam logic [PH_W-1:0] PH_HALF    = PH_W'(1) << (poi_pkg::HEAD_W - 1);
    localparam logic [IDX_W:0]  IDX_WRAP   = (IDX_W + 1)'(SINE_TABLE_ENTRIES);

    localparam logic signed [poi_pkg::PROD_W-1:0] RND_POS  = poi_pkg::PROD_W'(1) << 30;
    localparam logic signed [poi_pkg::PROD_W-1:0] RND_HEAD = poi_pkg::PROD_W'(1) << 19;

    typedef logic signed [poi_pkg::Q_W-1:0] rom_t [SINE_TABLE_ENTRIES];

    function automatic logic signed [poi_pkg::Q_W-1:0] q30_to_q15(input longint s);
        longint v;
        v = (s < 0) ? 64'sd0 : s;
        v = (v + 64'sd16384) >>> 15;
        if (v > 64'sd32767)
        begin
            v = 64'sd32767;
        end
        return poi_pkg::Q_W'(v);
    endfunction

    // Entry k holds sin(2*pi*k/N), built from a quarter-wave Taylor series in Q30.
    function automatic logic signed [poi_pkg::Q_W-1:0] table_entry(input longint unsigned k);
        longint unsigned q;
        longint unsigned r;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned ts;
        longint unsigned tc;
        longint ss;
        longint sc;
        logic signed [poi_pkg::Q_W-1:0] sv;
        logic signed [poi_pkg::Q_W-1:0] cv;
        logic signed [poi_pkg::Q_W-1:0] res;
        q  = (64'd4 * k) / ROM_N;
        r  = 64'd4 * k - q * ROM_N;
        a  = poi_pkg::PI_HALF_Q30 * r / ROM_N;
        a2 = (a * a) >> 30;
        ts = a;
        tc = 64'(poi_pkg::ONE_Q30);
        ss = longint'(a);
        sc = poi_pkg::ONE_Q30;
        for (int i = 1; i <= 7; i++)
        begin
            ts = ((ts * a2) >> 30) / poi_pkg::SIN_DIV[i-1];
            tc = ((tc * a2) >> 30) / poi_pkg::COS_DIV[i-1];
            if ((i % 2) == 1)
            begin
                ss = ss - longint'(ts);
                sc = sc - longint'(tc);
            end
            else
            begin
                ss = ss + longint'(ts);
                sc = sc + longint'(tc);
            end
        end
        sv = q30_to_q15(ss);
        cv = q30_to_q15(sc);
        case (q[1:0])
            2'd0:    res = sv;
            2'd1:    res = cv;
            2'd2:    res = -sv;
            default: res = -cv;
        endcase
        return res;
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++)
        begin
            t[k] = table_entry(64'(k));
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    poi_pkg::state_t  state_reg;
    poi_pkg::state_t  state_next;
    logic [poi_pkg::PC_W-1:0] pc_reg;
    logic [poi_pkg::PC_W-1:0] pc_next;
    poi_pkg::uword_t  uc;
    logic             out_free;
    logic             go;

    logic signed [poi_pkg::VEL_W-1:0]  vf_reg;
    logic signed [poi_pkg::VEL_W-1:0]  vs_reg;
    logic signed [poi_pkg::YAW_W-1:0]  wz_reg;
    logic        [poi_pkg::DT_W-1:0]   dt_reg;

    logic signed [poi_pkg::Q_W-1:0]    rom_q_reg;
    logic signed [poi_pkg::Q_W-1:0]    s_reg;
    logic signed [poi_pkg::Q_W-1:0]    c_reg;
    logic signed [poi_pkg::Q_W-1:0]    qz_reg;
    logic signed [poi_pkg::Q_W-1:0]    qw_reg;

    logic signed [poi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [poi_pkg::MUL_B_W-1:0] mul_b;
    logic signed [poi_pkg::PROD_W-1:0]  prod;
    logic signed [poi_pkg::PROD_W-1:0]  prod_reg;
    logic signed [poi_pkg::MUL_A_W-1:0] acc_reg;

    logic        [poi_pkg::HEAD_W-1:0] phase;
    logic        [PH_W-1:0]            ph_prod;
    logic        [IDX_W:0]             ph_round;
    logic        [IDX_W-1:0]           rom_idx;

    logic signed [poi_pkg::PROD_W-1:0] pos_rnd;
    logic signed [poi_pkg::PROD_W-1:0] head_rnd;
    logic signed [poi_pkg::POS_W-1:0]  pos_delta;
    logic        [poi_pkg::HEAD_W-1:0] head_delta;

    logic signed [poi_pkg::POS_W-1:0]  pos_x_reg;
    logic signed [poi_pkg::POS_W-1:0]  pos_y_reg;
    logic        [poi_pkg::HEAD_W-1:0] heading_reg;
    logic signed [poi_pkg::POS_W-1:0]  pos_x_next;
    logic signed [poi_pkg::POS_W-1:0]  pos_y_next;
    logic        [poi_pkg::HEAD_W-1:0] heading_next;

    logic                              out_valid_reg;
    logic signed [poi_pkg::POS_W-1:0]  out_pos_x_reg;
    logic signed [poi_pkg::POS_W-1:0]  out_pos_y_reg;
    logic        [poi_pkg::HEAD_W-1:0] out_heading_reg;
    logic signed [poi_pkg::Q_W-1:0]    out_qz_reg;
    logic signed [poi_pkg::Q_W-1:0]    out_qw_reg;

    assign uc       = poi_pkg::UCODE[pc_reg];
    assign out_free = !out_valid_reg || odom.ready;
    assign go       = (state_reg == poi_pkg::ST_RUN) &&
                      ((uc.seq != poi_pkg::SEQ_END) || out_free);

    assign cmd.ready = (state_reg == poi_pkg::ST_IDLE);

    assign odom.valid   = out_valid_reg;
    assign odom.pos_x   = out_pos_x_reg;
    assign odom.pos_y   = out_pos_y_reg;
    assign odom.heading = out_heading_reg;
    assign odom.quat_z  = out_qz_reg;
    assign odom.quat_w  = out_qw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= poi_pkg::ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            poi_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = poi_pkg::ST_RUN;
                    pc_next    = '0;
                end
            end
            poi_pkg::ST_RUN:
            begin
                if (go)
                begin
                    if (uc.seq == poi_pkg::SEQ_END)
                    begin
                        state_next = poi_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = poi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            vf_reg <= cmd.vel_forward;
            vs_reg <= cmd.vel_side;
            wz_reg <= cmd.yaw_rate;
            dt_reg <= cmd.elapsed_time;
        end
    end

    // Sine-table index: round(phase * N / 2^17) mod N.
    always_comb
    begin
        case (uc.rom)
            poi_pkg::ROM_SIN: phase = {heading_reg[15:0], 1'b0};
            poi_pkg::ROM_COS: phase = {heading_reg[15:0] + poi_pkg::PHASE_QUARTER, 1'b0};
            poi_pkg::ROM_QZ:  phase = heading_reg;
            poi_pkg::ROM_QW:  phase = heading_reg + poi_pkg::HEAD_HALF;
            default:          phase = '0;
        endcase
        ph_prod  = PH_W'(phase) * PH_ENTRIES + PH_HALF;
        ph_round = ph_prod[PH_W-1:poi_pkg::HEAD_W];
        rom_idx  = (ph_round == IDX_WRAP) ? '0 : ph_round[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (go && (uc.rom != poi_pkg::ROM_NONE))
        begin
            rom_q_reg <= SINE_ROM[rom_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            case (uc.cap)
                poi_pkg::CAP_S:  s_reg  <= rom_q_reg;
                poi_pkg::CAP_C:  c_reg  <= rom_q_reg;
                poi_pkg::CAP_QZ: qz_reg <= rom_q_reg;
                poi_pkg::CAP_QW: qw_reg <= rom_q_reg;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uc.mul)
            poi_pkg::MUL_WZ_DT:
            begin
                mul_a = poi_pkg::MUL_A_W'(wz_reg);
                mul_b = {1'b0, dt_reg};
            end
            poi_pkg::MUL_VF_S:
            begin
                mul_a = poi_pkg::MUL_A_W'(vf_reg);
                mul_b = poi_pkg::MUL_B_W'(s_reg);
            end
            poi_pkg::MUL_VS_C:
            begin
                mul_a = poi_pkg::MUL_A_W'(vs_reg);
                mul_b = poi_pkg::MUL_B_W'(c_reg);
            end
            poi_pkg::MUL_VF_C:
            begin
                mul_a = poi_pkg::MUL_A_W'(vf_reg);
                mul_b = poi_pkg::MUL_B_W'(c_reg);
            end
            poi_pkg::MUL_VS_S:
            begin
                mul_a = poi_pkg::MUL_A_W'(vs_reg);
                mul_b = poi_pkg::MUL_B_W'(s_reg);
            end
            poi_pkg::MUL_ACC_DT:
            begin
                mul_a = acc_reg;
                mul_b = {1'b0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (go && (uc.mul != poi_pkg::MUL_NONE))
        begin
            prod_reg <= prod;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            case (uc.acc)
                poi_pkg::ACC_LOAD: acc_reg <= poi_pkg::MUL_A_W'(prod_reg);
                poi_pkg::ACC_ADD:  acc_reg <= acc_reg + poi_pkg::MUL_A_W'(prod_reg);
                poi_pkg::ACC_SUB:  acc_reg <= acc_reg - poi_pkg::MUL_A_W'(prod_reg);
                default:           ;
            endcase
        end
    end

    // Position deltas round half up from 2^-47 m to 2^-16 m; heading deltas by 2^20.
    always_comb
    begin
        pos_rnd    = prod_reg + RND_POS;
        head_rnd   = prod_reg + RND_HEAD;
        pos_delta  = poi_pkg::POS_W'(pos_rnd >>> 31);
        head_delta = head_rnd[poi_pkg::HEAD_W+19:20];

        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        if (go)
        begin
            case (uc.wb)
                poi_pkg::WB_HEADING: heading_next = heading_reg + head_delta;
                poi_pkg::WB_Y:       pos_y_next   = pos_y_reg + pos_delta;
                poi_pkg::WB_X:       pos_x_next   = pos_x_reg + pos_delta;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && (uc.seq == poi_pkg::SEQ_END))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (odom.valid && odom.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && (uc.seq == poi_pkg::SEQ_END))
        begin
            out_pos_x_reg   <= pos_x_next;
            out_pos_y_reg   <= pos_y_next;
            out_heading_reg <= heading_next;
            out_qz_reg      <= qz_reg;
            out_qw_reg      <= qw_reg;
        end
    end

    `POI_ASSERT_NEXT(a_accept_starts_program, clk, rst_n, cmd.valid && cmd.ready, state_reg == poi_pkg::ST_RUN && pc_reg == '0, "Accepted request did not start the program at step zero")
    `POI_ASSERT_NEXT(a_end_step_delivers, clk, rst_n, go && uc.seq == poi_pkg::SEQ_END, odom.valid && state_reg == poi_pkg::ST_IDLE, "Final step did not present a result")
    `POI_ASSERT_NEXT(a_heading_only_on_wb, clk, rst_n, !(go && uc.wb == poi_pkg::WB_HEADING), $stable(heading_reg), "Heading changed outside its writeback step")
    `POI_ASSERT_NEXT(a_idle_position_stable, clk, rst_n, state_reg == poi_pkg::ST_IDLE, $stable(pos_x_reg) && $stable(pos_y_reg), "Position changed while idle")
    `POI_ASSERT_SAME(a_pc_in_program, clk, rst_n, state_reg == poi_pkg::ST_RUN, pc_reg <= poi_pkg::PC_LAST, "Step counter ran past the program")

endmodule

`default_nettype wire
